@@ rtl/core/plc_pkg.sv @@
`default_nettype none

package plc_pkg;

    // Field widths fixed by the item format
    localparam int POS_W   = 9;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 9;

    // Default sizing of the list
    localparam int LIST_DEPTH_DEF = 256;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } plc_op_t;

    typedef struct packed {
        plc_op_t              operation;
        logic [POS_W-1:0]     position;
        logic [VALUE_W-1:0]   value;
    } plc_req_t;

    typedef struct packed {
        logic                 ok;
        logic [VALUE_W-1:0]   read_data;
        logic [COUNT_W-1:0]   entry_count;
    } plc_rsp_t;

    // Shift command broadcast to every cell of the row
    typedef struct packed {
        logic ins;
        logic del;
    } plc_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/plc_cell.sv @@
`default_nettype none

module plc_cell
    import plc_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int SLOT_W     = 8,
    parameter int IDX        = 0
)
(
    input  wire logic                  clk,
    input  wire plc_ctl_t              ctl,
    input  wire logic [SLOT_W-1:0]     slot,
    input  wire logic [DATA_WIDTH-1:0] new_data,
    input  wire logic [DATA_WIDTH-1:0] left_data,
    input  wire logic [DATA_WIDTH-1:0] right_data,
    output logic      [DATA_WIDTH-1:0] data,
    output logic      [DATA_WIDTH-1:0] hit_data
);

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  at_slot;
    logic                  past_slot;

    assign at_slot   = (slot == MY_SLOT);
    assign past_slot = (MY_SLOT > slot);

    // Pick the entry for the next cycle: take new item, shift up, shift down or hold
    always_comb
    begin
        data_next = data_reg;
        if (ctl.ins && at_slot)
        begin
            data_next = new_data;
        end
        else if (ctl.ins && past_slot)
        begin
            data_next = left_data;
        end
        else if (ctl.del && (at_slot || past_slot))
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // Drive the read bus only when addressed
    assign data     = data_reg;
    assign hit_data = at_slot ? data_reg : '0;

endmodule

`default_nettype wire

@@ rtl/core/positional_list_store_top.sv @@
// Ordered list of up to LIST_DEPTH entries with 1-based positions. Each item is
// insert, delete, read or clear and gives exactly one result, held in an output
// register from the cycle after the item is accepted. The entries sit in a row of
// LIST_DEPTH cells; those at and past the addressed position all shift toward or
// away from it in the same cycle, so a new item is accepted every cycle while the
// result register is free or being emptied; req_stall rises only
// while a result waits under rsp_stall. No clearing pass follows
// reset: entries past the count are never read. An insert into a full list and
// any position outside the valid range give ok = 0 and leave the list as it was.
`default_nettype none

module positional_list_store_top
    import plc_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire plc_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output plc_rsp_t      rsp
);

    localparam int SLOT_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam logic [CMP_W-1:0] DEPTH_X = CMP_W'(LIST_DEPTH);

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    plc_rsp_t              rsp_reg;
    plc_rsp_t              rsp_next;

    logic                  accept;
    logic [CMP_W-1:0]      pos_x;
    logic [CMP_W-1:0]      cnt_x;
    logic                  ins_ok;
    logic                  sel_ok;
    logic [SLOT_W-1:0]     slot;
    plc_ctl_t              ctl;
    logic [DATA_WIDTH-1:0] new_data;
    logic [DATA_WIDTH-1:0] read_bus;

    logic [DATA_WIDTH-1:0] cell_q   [LIST_DEPTH];
    logic [DATA_WIDTH-1:0] cell_hit [LIST_DEPTH];

    // Accept unless a result waits under stall
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    // Range checks on the requested position
    assign pos_x  = CMP_W'(req.position);
    assign cnt_x  = CMP_W'(count_reg);
    assign ins_ok = (pos_x != '0) && (pos_x <= cnt_x + CMP_W'(1)) && (cnt_x < DEPTH_X);
    assign sel_ok = (pos_x != '0) && (pos_x <= cnt_x);
    assign slot   = SLOT_W'(pos_x - CMP_W'(1));

    assign new_data = DATA_WIDTH'(req.value);

    // Broadcast shift command to the row
    always_comb
    begin
        ctl.ins = accept && (req.operation == OP_INSERT) && ins_ok;
        ctl.del = accept && (req.operation == OP_DELETE) && sel_ok;
    end

    // Row of cells
    for (genvar g = 0; g < LIST_DEPTH; g++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;

        if (g == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_left
            assign left_d = cell_q[g-1];
        end

        if (g == LIST_DEPTH - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_right
            assign right_d = cell_q[g+1];
        end

        plc_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .SLOT_W     (SLOT_W),
            .IDX        (g)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .slot       (slot),
            .new_data   (new_data),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_q[g]),
            .hit_data   (cell_hit[g])
        );
    end

    // Merge the addressed cell onto the read bus
    always_comb
    begin
        read_bus = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            read_bus = read_bus | cell_hit[i];
        end
    end

    // Form the result and the new count
    always_comb
    begin
        count_next = count_reg;
        rsp_next   = rsp_reg;
        if (accept)
        begin
            rsp_next.ok        = 1'b0;
            rsp_next.read_data = '0;
            case (req.operation)
                OP_INSERT:
                begin
                    if (ins_ok)
                    begin
                        rsp_next.ok = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
                OP_DELETE:
                begin
                    if (sel_ok)
                    begin
                        rsp_next.ok        = 1'b1;
                        rsp_next.read_data = VALUE_W'(read_bus);
                        count_next         = count_reg - CNT_W'(1);
                    end
                end
                OP_READ:
                begin
                    if (sel_ok)
                    begin
                        rsp_next.ok        = 1'b1;
                        rsp_next.read_data = VALUE_W'(read_bus);
                    end
                end
                OP_CLEAR:
                begin
                    rsp_next.ok = 1'b1;
                    count_next  = '0;
                end
                default:
                begin
                    rsp_next.ok = 1'b0;
                end
            endcase
            rsp_next.entry_count = COUNT_W'(count_next);
        end
    end

    // Load on accept, drop when taken
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

@@ rtl/core/plc_checker.sv @@
`default_nettype none

module plc_checker
    import plc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    input  wire logic     req_stall,
    input  wire plc_req_t req,
    input  wire logic     rsp_valid,
    input  wire logic     rsp_stall,
    input  wire plc_rsp_t rsp
);

    // Hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

    // Every accepted item shows a result next cycle
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> rsp_valid)
        else $error("accepted item gave no result");

    // Clear always succeeds and empties the list
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req.operation == OP_CLEAR)
        |=> rsp.ok && (rsp.entry_count == '0) && (rsp.read_data == '0))
        else $error("clear result wrong");

    // A refused item returns no data
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.ok |-> rsp.read_data == '0)
        else $error("failed item returned data");

endmodule

bind positional_list_store_top plc_checker u_plc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire

@@ verif/tb_positional_list_store_top.sv @@
`timescale 1ns / 1ps

module tb_positional_list_store_top;
    import plc_pkg::*;

    localparam int LIST_DEPTH   = LIST_DEPTH_DEF;
    localparam int DATA_WIDTH   = DATA_WIDTH_DEF;
    localparam int RANDOM_ITEMS = 1880;
    localparam int TOTAL_ITEMS  = RANDOM_ITEMS + 24;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;
    localparam logic [VALUE_W-1:0] DATA_MASK = {VALUE_W{1'b1}} >> (VALUE_W - DATA_WIDTH);

    typedef struct {
        plc_req_t item;
        bit       typed;
        plc_rsp_t want;
    } stim_row_t;

    typedef enum {EP_GROW, EP_FULL, EP_SHRINK, EP_MIX} episode_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    plc_req_t req       = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    plc_rsp_t rsp;

    // Mirror of the list contents and fill level
    logic [VALUE_W-1:0] list_mirror [LIST_DEPTH];
    int unsigned        mirror_count = 0;

    plc_rsp_t    pending_rsps[$];
    stim_row_t   stim_table[$];
    int unsigned items_sent     = 0;
    int unsigned rsps_checked   = 0;
    int unsigned mismatch_count = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned rsp_stall_pct  = 0;

    // Tallies for the closing summary
    int unsigned n_ins_ok      = 0;
    int unsigned n_ins_full    = 0;
    int unsigned n_bad_pos     = 0;
    int unsigned n_del_ok      = 0;
    int unsigned n_read_ok     = 0;
    int unsigned n_clear       = 0;
    int unsigned peak_count    = 0;

    episode_t    episode = EP_GROW;
    int unsigned ep_left = 0;

    positional_list_store_top #(
        .LIST_DEPTH (LIST_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Apply one item to the mirror and return the result it should give
    function automatic plc_rsp_t apply_list_op(input plc_req_t r);
        plc_rsp_t    res;
        int unsigned pos;
        int          i;
        res = '0;
        pos = r.position;
        case (r.operation)
            OP_INSERT:
            begin
                if (mirror_count == LIST_DEPTH)
                    n_ins_full++;
                else if (pos >= 1 && pos <= mirror_count + 1)
                begin
                    for (i = mirror_count; i > int'(pos) - 1; i--)
                        list_mirror[i] = list_mirror[i-1];
                    list_mirror[pos-1] = r.value & DATA_MASK;
                    mirror_count++;
                    res.ok = 1'b1;
                    n_ins_ok++;
                end
                else
                    n_bad_pos++;
            end
            OP_DELETE, OP_READ:
            begin
                if (pos >= 1 && pos <= mirror_count)
                begin
                    res.read_data = list_mirror[pos-1];
                    res.ok        = 1'b1;
                    if (r.operation == OP_DELETE)
                    begin
                        for (i = pos - 1; i + 1 < int'(mirror_count); i++)
                            list_mirror[i] = list_mirror[i+1];
                        mirror_count--;
                        n_del_ok++;
                    end
                    else
                        n_read_ok++;
                end
                else
                    n_bad_pos++;
            end
            default:
            begin
                mirror_count = 0;
                res.ok       = 1'b1;
                n_clear++;
            end
        endcase
        if (mirror_count > peak_count)
            peak_count = mirror_count;
        res.entry_count = COUNT_W'(mirror_count);
        return res;
    endfunction

    // Pick the next random item; episodes walk the list from empty to full and back
    function automatic plc_req_t next_random_item();
        plc_req_t    it;
        int unsigned roll;
        int unsigned hi;
        int unsigned pos;
        case (episode)
            EP_GROW:
            begin
                if (mirror_count == LIST_DEPTH)
                begin
                    episode = EP_FULL;
                    ep_left = 14;
                end
            end
            EP_FULL:
            begin
                if (ep_left == 0)
                    episode = EP_SHRINK;
            end
            EP_SHRINK:
            begin
                if (mirror_count == 0)
                begin
                    episode = EP_MIX;
                    ep_left = $urandom_range(200, 100);
                end
            end
            default:
            begin
                if (ep_left == 0)
                    episode = EP_GROW;
            end
        endcase
        if (ep_left != 0)
            ep_left--;

        roll = $urandom_range(99);
        case (episode)
            EP_GROW:
                it.operation = roll < 80 ? OP_INSERT : roll < 90 ? OP_READ : OP_DELETE;
            EP_FULL:
                it.operation = roll < 60 ? OP_INSERT : roll < 88 ? OP_READ : OP_DELETE;
            EP_SHRINK:
                it.operation = roll < 68 ? OP_DELETE : roll < 83 ? OP_READ :
                               roll < 99 ? OP_INSERT : OP_CLEAR;
            default:
                it.operation = roll < 34 ? OP_INSERT : roll < 64 ? OP_DELETE :
                               roll < 97 ? OP_READ : OP_CLEAR;
        endcase

        // Mostly legal positions, with the ends and out-of-range ones mixed in
        hi   = (it.operation == OP_INSERT) ? mirror_count + 1 : mirror_count;
        roll = $urandom_range(99);
        if (roll < 8)
            pos = 1;
        else if (roll < 16)
            pos = hi;
        else if (roll < 84)
            pos = (hi >= 1) ? $urandom_range(hi, 1) : 1;
        else if (roll < 88)
            pos = 0;
        else if (roll < 94)
            pos = hi + 1;
        else
            pos = $urandom_range(511);
        it.position = POS_W'(pos);

        roll = $urandom_range(99);
        it.value = roll < 5 ? '0 : roll < 10 ? '1 : VALUE_W'($urandom);
        return it;
    endfunction

    // Present one item, hold it until taken, then record what it should give
    task automatic push_item(input plc_req_t item, input bit typed, input plc_rsp_t want);
        plc_rsp_t predicted;
        int unsigned phase;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
        predicted = apply_list_op(item);
        pending_rsps.push_back(typed ? want : predicted);
        items_sent++;

        // Step through the idling phases as the run goes on
        phase = items_sent * 4 / TOTAL_ITEMS;
        case (phase)
            0:
            begin
                send_idle_pct = 0;
                rsp_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct = 52;
                rsp_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                rsp_stall_pct = 52;
            end
            default:
            begin
                send_idle_pct = 24;
                rsp_stall_pct = 24;
            end
        endcase
    endtask

    task automatic add_row(input plc_op_t op, input logic [POS_W-1:0] pos,
                           input logic [VALUE_W-1:0] val, input bit typed,
                           input logic ok, input logic [VALUE_W-1:0] data,
                           input logic [COUNT_W-1:0] cnt);
        stim_row_t row;
        row.item  = '{operation: op, position: pos, value: val};
        row.typed = typed;
        row.want  = '{ok: ok, read_data: data, entry_count: cnt};
        stim_table.push_back(row);
    endtask

    // Stall the result side at random
    always @(posedge clk)
    begin
        rsp_stall <= (rsp_stall_pct != 0 && $urandom_range(99) < rsp_stall_pct);
    end

    // Compare each taken result with the oldest expectation
    always @(posedge clk)
    begin
        plc_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsps.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("[%0t] unexpected result: ok=%0b data=%h count=%0d",
                             $realtime, rsp.ok, rsp.read_data, rsp.entry_count);
            end
            else
            begin
                want = pending_rsps.pop_front();
                rsps_checked++;
                if (rsp.ok !== want.ok || rsp.read_data !== want.read_data ||
                    rsp.entry_count !== want.entry_count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("[%0t] result %0d mismatch: exp ok=%0b data=%h count=%0d",
                                 $realtime, rsps_checked, want.ok, want.read_data,
                                 want.entry_count);
                        $display("    got ok=%0b data=%h count=%0d",
                                 rsp.ok, rsp.read_data, rsp.entry_count);
                    end
                end
            end
        end
    end

    initial
    begin
        int idx;

        // Empty list: reads, deletes and out-of-range inserts fail, clear still succeeds
        add_row(OP_READ,   9'd1,   32'h0000_0000, 1, 1'b0, 32'h0, 9'd0);
        add_row(OP_DELETE, 9'd0,   32'h0000_0000, 1, 1'b0, 32'h0, 9'd0);
        add_row(OP_INSERT, 9'd0,   32'h0000_1234, 1, 1'b0, 32'h0, 9'd0);
        add_row(OP_INSERT, 9'd2,   32'h0000_1234, 1, 1'b0, 32'h0, 9'd0);
        add_row(OP_CLEAR,  9'd511, 32'hFFFF_FFFF, 1, 1'b1, 32'h0, 9'd0);
        // Build up: front, front, append, middle, then beyond the end
        add_row(OP_INSERT, 9'd1,   32'hFFFF_FFFF, 1, 1'b1, 32'h0, 9'd1);
        add_row(OP_INSERT, 9'd1,   32'h0000_0000, 1, 1'b1, 32'h0, 9'd2);
        add_row(OP_INSERT, 9'd3,   32'hA5A5_A5A5, 1, 1'b1, 32'h0, 9'd3);
        add_row(OP_INSERT, 9'd2,   32'h5A5A_5A5A, 1, 1'b1, 32'h0, 9'd4);
        add_row(OP_INSERT, 9'd6,   32'h0000_0001, 1, 1'b0, 32'h0, 9'd4);
        add_row(OP_READ,   9'd1,   32'hFFFF_FFFF, 0, 1'b0, 32'h0, 9'd0);
        add_row(OP_READ,   9'd4,   32'h0000_0000, 0, 1'b0, 32'h0, 9'd0);
        add_row(OP_READ,   9'd5,   32'h0000_0000, 1, 1'b0, 32'h0, 9'd4);
        add_row(OP_READ,   9'd511, 32'h0000_0000, 1, 1'b0, 32'h0, 9'd4);
        add_row(OP_DELETE, 9'd5,   32'hFFFF_FFFF, 1, 1'b0, 32'h0, 9'd4);
        add_row(OP_DELETE, 9'd256, 32'h0000_0000, 1, 1'b0, 32'h0, 9'd4);
        // Remove from middle and end, read what closed the gap
        add_row(OP_DELETE, 9'd2,   32'h0000_0000, 0, 1'b0, 32'h0, 9'd0);
        add_row(OP_READ,   9'd2,   32'h0000_0000, 0, 1'b0, 32'h0, 9'd0);
        add_row(OP_DELETE, 9'd3,   32'h0000_0000, 0, 1'b0, 32'h0, 9'd0);
        add_row(OP_INSERT, 9'd3,   32'h8000_0001, 0, 1'b0, 32'h0, 9'd0);
        add_row(OP_DELETE, 9'd1,   32'h0000_0000, 0, 1'b0, 32'h0, 9'd0);
        add_row(OP_CLEAR,  9'd0,   32'h0000_0000, 1, 1'b1, 32'h0, 9'd0);
        add_row(OP_DELETE, 9'd1,   32'h0000_0000, 1, 1'b0, 32'h0, 9'd0);
        add_row(OP_READ,   9'd0,   32'h0000_0000, 1, 1'b0, 32'h0, 9'd0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[idx])
            push_item(stim_table[idx].item, stim_table[idx].typed, stim_table[idx].want);

        for (idx = 0; idx < RANDOM_ITEMS; idx++)
            push_item(next_random_item(), 1'b0, '0);

        // Drain the remaining results
        req_valid <= 1'b0;
        while (pending_rsps.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("items %0d, results checked %0d, mismatches %0d, peak fill %0d of %0d",
                 items_sent, rsps_checked, mismatch_count, peak_count, LIST_DEPTH);
        $display("inserts %0d, refused full %0d, bad pos %0d, deletes %0d, reads %0d, clears %0d",
                 n_ins_ok, n_ins_full, n_bad_pos, n_del_ok, n_read_ok, n_clear);
        if (mismatch_count == 0 && pending_rsps.size() == 0)
            $display("tb_positional_list_store_top: PASS");
        else
            $display("tb_positional_list_store_top: FAIL");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2_000_000;
        $display("tb_positional_list_store_top: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/plc_pkg.sv
rtl/core/plc_cell.sv
rtl/core/positional_list_store_top.sv
rtl/core/plc_checker.sv
verif/tb_positional_list_store_top.sv
